FILE: rtl/wfit_pkg.sv
package wfit_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int COUNT_BITS  = 40;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int USED_W      = CNT_W;

  // field widths
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 64;
  localparam int WEIGHT_W = 16;
  localparam int SLOT_W   = 6;
  localparam int OUTC_W   = 3;
  localparam int OCC_W    = 7;
  localparam int CAP_W    = 7;
  localparam int CMP_W    = (USED_W > CAP_W) ? USED_W : CAP_W;

  localparam int IN_TDATA_W  = ((KEY_W + WEIGHT_W + SLOT_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((1 + KEY_W + COUNT_BITS + OCC_W + 7) / 8) * 8;
  localparam int IN_TUSER_W  = CMD_W;
  localparam int OUT_TUSER_W = OUTC_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CAP_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
  localparam logic [CAP_W-1:0]      CAP_RESET  = 7'd64;
  localparam logic [KEY_W-1:0]      NARROW_MASK = 64'h0000_0000_FFFF_FFFF;

  // commands
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // outcomes
  localparam logic [OUTC_W-1:0] OUT_ADDED        = 3'd0;
  localparam logic [OUTC_W-1:0] OUT_INSERTED     = 3'd1;
  localparam logic [OUTC_W-1:0] OUT_DEC_INSERTED = 3'd2;
  localparam logic [OUTC_W-1:0] OUT_DEC_DROPPED  = 3'd3;
  localparam logic [OUTC_W-1:0] OUT_READ         = 3'd4;
  localparam logic [OUTC_W-1:0] OUT_CLEARED      = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_KEYS = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DEC,
    ST_PLACE,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CAP_W-1:0] capacity;
    logic             wide;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [KEY_W-1:0]    key;
    logic [WEIGHT_W-1:0] weight;
    logic [SLOT_W-1:0]   slot;
  } req_t;

  typedef struct packed {
    logic [OUTC_W-1:0]     outcome;
    logic                  slot_valid;
    logic [KEY_W-1:0]      slot_key;
    logic [COUNT_BITS-1:0] slot_count;
    logic [OCC_W-1:0]      occupancy;
  } res_t;

endpackage

FILE: rtl/wfit_ram.sv
module wfit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

endmodule

FILE: rtl/wfit_seq.sv
module wfit_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  wfit_pkg::cfg_t cfg,
  input  logic          req_valid,
  input  wfit_pkg::req_t req,
  output logic          req_ready,
  output logic          res_valid,
  input  logic          res_take,
  output wfit_pkg::res_t res
);

  wfit_pkg::state_t state_r, state_nxt;

  logic [wfit_pkg::CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [wfit_pkg::KEY_W-1:0]      key_r, key_nxt;
  logic [wfit_pkg::WEIGHT_W-1:0]   weight_r, weight_nxt;
  logic [wfit_pkg::SLOT_W-1:0]     slot_r, slot_nxt;
  logic [wfit_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            chk_vld_r, chk_vld_nxt;
  logic [wfit_pkg::IDX_W-1:0]      chk_idx_r, chk_idx_nxt;
  logic                            free_found_r, free_found_nxt;
  logic [wfit_pkg::IDX_W-1:0]      free_idx_r, free_idx_nxt;
  logic [wfit_pkg::COUNT_BITS-1:0] min_r, min_nxt;
  logic [wfit_pkg::TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [wfit_pkg::USED_W-1:0]     used_r, used_nxt;
  logic [wfit_pkg::OUTC_W-1:0]     outc_r, outc_nxt;
  logic                            sv_r, sv_nxt;
  logic [wfit_pkg::KEY_W-1:0]      sk_r, sk_nxt;
  logic [wfit_pkg::COUNT_BITS-1:0] sc_r, sc_nxt;

  // memory ports
  logic                            key_we, cnt_we;
  logic [wfit_pkg::IDX_W-1:0]      waddr, raddr;
  logic [wfit_pkg::COUNT_BITS-1:0] cnt_wdata;
  logic [wfit_pkg::KEY_W-1:0]      key_rd;
  logic [wfit_pkg::COUNT_BITS-1:0] cnt_rd;

  // shared datapath terms
  logic [wfit_pkg::KEY_W-1:0]      key_mask;
  logic [wfit_pkg::COUNT_BITS-1:0] weight_ext;
  logic                            ent_v, key_eq, hit, issue, last_chk;
  logic [wfit_pkg::COUNT_BITS:0]   sum;
  logic [wfit_pkg::COUNT_BITS-1:0] added, dec_val, min_upd;
  logic                            dec_zero, free_here, free_any;
  logic [wfit_pkg::IDX_W-1:0]      free_sel;
  logic [wfit_pkg::USED_W-1:0]     used_dec;
  logic [wfit_pkg::CMP_W-1:0]      cap_eff;
  logic                            room_scan, room_dec, place_ok, slot_in_range;

  wfit_ram #(.WIDTH(wfit_pkg::KEY_W), .DEPTH(wfit_pkg::TABLE_DEPTH)) u_key_ram (
    .clk      (clk),
    .we       (key_we),
    .waddr    (waddr),
    .wdata    (key_r),
    .raddr    (raddr),
    .rd_data_r(key_rd)
  );

  wfit_ram #(.WIDTH(wfit_pkg::COUNT_BITS), .DEPTH(wfit_pkg::TABLE_DEPTH)) u_cnt_ram (
    .clk      (clk),
    .we       (cnt_we),
    .waddr    (waddr),
    .wdata    (cnt_wdata),
    .raddr    (raddr),
    .rd_data_r(cnt_rd)
  );

  assign key_mask   = cfg.wide ? '1 : wfit_pkg::NARROW_MASK;
  assign weight_ext = wfit_pkg::COUNT_BITS'(weight_r);
  assign ent_v      = valid_r[chk_idx_r];
  assign key_eq     = ((key_rd ^ key_r) & key_mask) == '0;
  assign hit        = chk_vld_r && ent_v && key_eq;
  assign issue      = cnt_r < wfit_pkg::CNT_W'(wfit_pkg::TABLE_DEPTH);
  assign last_chk   = chk_vld_r && (chk_idx_r == wfit_pkg::IDX_W'(wfit_pkg::TABLE_DEPTH - 1));

  // saturating add
  assign sum   = {1'b0, cnt_rd} + {1'b0, weight_ext};
  assign added = sum[wfit_pkg::COUNT_BITS] ? wfit_pkg::COUNT_MAX
                                           : sum[wfit_pkg::COUNT_BITS-1:0];

  assign dec_val  = cnt_rd - min_r;
  assign dec_zero = ent_v && (dec_val == '0);
  assign min_upd  = (chk_vld_r && ent_v && (cnt_rd < min_r)) ? cnt_rd : min_r;

  // a slot counts as free if empty, or during the decrement pass if it just hit zero
  assign free_here = chk_vld_r && (!ent_v || ((state_r == wfit_pkg::ST_DEC) && dec_zero));
  assign free_any  = free_found_r || free_here;
  assign free_sel  = free_found_r ? free_idx_r : chk_idx_r;

  assign used_dec = used_r - wfit_pkg::USED_W'(chk_vld_r && dec_zero);

  assign cap_eff = (wfit_pkg::CMP_W'(cfg.capacity) > wfit_pkg::CMP_W'(wfit_pkg::TABLE_DEPTH))
                 ? wfit_pkg::CMP_W'(wfit_pkg::TABLE_DEPTH) : wfit_pkg::CMP_W'(cfg.capacity);
  assign room_scan = wfit_pkg::CMP_W'(used_r) < cap_eff;
  assign room_dec  = wfit_pkg::CMP_W'(used_dec) < cap_eff;
  assign place_ok  = (min_r < weight_ext) && room_dec && free_any;

  assign slot_in_range = 32'(slot_r) < 32'(wfit_pkg::TABLE_DEPTH);

  assign req_ready = state_r == wfit_pkg::ST_IDLE;
  assign res_valid = state_r == wfit_pkg::ST_DONE;
  assign res.outcome    = outc_r;
  assign res.slot_valid = sv_r;
  assign res.slot_key   = sk_r;
  assign res.slot_count = sc_r;
  assign res.occupancy  = wfit_pkg::OCC_W'(used_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wfit_pkg::ST_IDLE: begin
        if (req_valid) begin
          case (req.cmd)
            wfit_pkg::CMD_UPDATE: state_nxt = wfit_pkg::ST_SCAN;
            wfit_pkg::CMD_CLEAR:  state_nxt = wfit_pkg::ST_CLEAR;
            default:              state_nxt = wfit_pkg::ST_RD_ADDR;
          endcase
        end
      end
      wfit_pkg::ST_SCAN: begin
        if (hit) begin
          state_nxt = wfit_pkg::ST_DONE;
        end else if (last_chk) begin
          state_nxt = room_scan ? wfit_pkg::ST_DONE : wfit_pkg::ST_DEC;
        end
      end
      wfit_pkg::ST_DEC: begin
        if (last_chk) begin
          state_nxt = place_ok ? wfit_pkg::ST_PLACE : wfit_pkg::ST_DONE;
        end
      end
      wfit_pkg::ST_PLACE:   state_nxt = wfit_pkg::ST_DONE;
      wfit_pkg::ST_RD_ADDR: state_nxt = wfit_pkg::ST_RD_DATA;
      wfit_pkg::ST_RD_DATA: state_nxt = wfit_pkg::ST_DONE;
      wfit_pkg::ST_CLEAR:   state_nxt = wfit_pkg::ST_DONE;
      wfit_pkg::ST_DONE: begin
        if (res_take) begin
          state_nxt = wfit_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wfit_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    weight_nxt     = weight_r;
    slot_nxt       = slot_r;
    cnt_nxt        = cnt_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    min_nxt        = min_r;
    valid_nxt      = valid_r;
    used_nxt       = used_r;
    outc_nxt       = outc_r;
    sv_nxt         = sv_r;
    sk_nxt         = sk_r;
    sc_nxt         = sc_r;
    key_we         = 1'b0;
    cnt_we         = 1'b0;
    waddr          = chk_idx_r;
    cnt_wdata      = dec_val;
    raddr          = cnt_r[wfit_pkg::IDX_W-1:0];

    case (state_r)
      wfit_pkg::ST_IDLE: begin
        if (req_valid) begin
          cmd_nxt        = req.cmd;
          key_nxt        = req.key & key_mask;
          weight_nxt     = req.weight;
          slot_nxt       = req.slot;
          cnt_nxt        = '0;
          free_found_nxt = 1'b0;
          min_nxt        = wfit_pkg::COUNT_BITS'(req.weight);
          sv_nxt         = 1'b0;
          sk_nxt         = '0;
          sc_nxt         = '0;
        end
      end

      wfit_pkg::ST_SCAN: begin
        if (issue) begin
          cnt_nxt     = cnt_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = cnt_r[wfit_pkg::IDX_W-1:0];
        end
        min_nxt = min_upd;
        if (!free_found_r && free_here) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = chk_idx_r;
        end
        if (hit) begin
          cnt_we    = 1'b1;
          cnt_wdata = added;
          outc_nxt  = wfit_pkg::OUT_ADDED;
        end else if (last_chk) begin
          if (room_scan) begin
            if (free_any) begin
              key_we              = 1'b1;
              cnt_we              = 1'b1;
              waddr               = free_sel;
              cnt_wdata           = weight_ext;
              valid_nxt[free_sel] = 1'b1;
              used_nxt            = used_r + 1'b1;
              outc_nxt            = wfit_pkg::OUT_INSERTED;
            end else begin
              outc_nxt = wfit_pkg::OUT_DEC_DROPPED;
            end
          end else begin
            // table full: restart the walk for the decrement pass
            cnt_nxt        = '0;
            chk_vld_nxt    = 1'b0;
            free_found_nxt = 1'b0;
          end
        end
      end

      wfit_pkg::ST_DEC: begin
        if (issue) begin
          cnt_nxt     = cnt_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = cnt_r[wfit_pkg::IDX_W-1:0];
        end
        if (chk_vld_r && ent_v) begin
          cnt_we = 1'b1;
          if (dec_zero) begin
            valid_nxt[chk_idx_r] = 1'b0;
          end
        end
        used_nxt = used_dec;
        if (!free_found_r && free_here) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = chk_idx_r;
        end
        if (last_chk && !place_ok) begin
          outc_nxt = wfit_pkg::OUT_DEC_DROPPED;
        end
      end

      wfit_pkg::ST_PLACE: begin
        key_we                = 1'b1;
        cnt_we                = 1'b1;
        waddr                 = free_idx_r;
        cnt_wdata             = weight_ext - min_r;
        valid_nxt[free_idx_r] = 1'b1;
        used_nxt              = used_r + 1'b1;
        outc_nxt              = wfit_pkg::OUT_DEC_INSERTED;
      end

      wfit_pkg::ST_RD_ADDR: begin
        raddr = wfit_pkg::IDX_W'(slot_r);
      end

      wfit_pkg::ST_RD_DATA: begin
        outc_nxt = wfit_pkg::OUT_READ;
        if (slot_in_range && valid_r[wfit_pkg::IDX_W'(slot_r)]) begin
          sv_nxt = 1'b1;
          sk_nxt = key_rd;
          sc_nxt = cnt_rd;
        end
      end

      wfit_pkg::ST_CLEAR: begin
        valid_nxt = '0;
        used_nxt  = '0;
        outc_nxt  = wfit_pkg::OUT_CLEARED;
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= wfit_pkg::ST_IDLE;
      chk_vld_r <= 1'b0;
      valid_r   <= '0;
      used_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= chk_vld_nxt;
      valid_r   <= valid_nxt;
      used_r    <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    weight_r     <= weight_nxt;
    slot_r       <= slot_nxt;
    cnt_r        <= cnt_nxt;
    chk_idx_r    <= chk_idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    min_r        <= min_nxt;
    outc_r       <= outc_nxt;
    sv_r         <= sv_nxt;
    sk_r         <= sk_nxt;
    sc_r         <= sc_nxt;
  end

endmodule

FILE: rtl/weighted_frequent_item_table_unit.sv
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------------
// in       | in_tvalid/in_tready  | tuser: command; tdata: key, weight, slot index
// out      | out_tvalid/out_tready| tuser: outcome; tdata: valid, key, count, occupancy
// cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data (0 capacity, 1 wide keys)
//
// an update walks the key and count memories one slot a cycle: a hit ends the walk
// at the matching slot, a miss walks every slot, and a full table takes a second,
// decrement walk; read and clear take no walk
// the single read port of the memories sets that rate
// reset clears the valid bits and the fill count at once, no clearing pass
// a finished word sits in the output register while the next word is taken in;
// a stalled output only holds the sequencer once its next result is ready
module weighted_frequent_item_table_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: item_key [63:0], weight [79:64], slot_index [85:80], zero pad
  input  logic [wfit_pkg::IN_TDATA_W-1:0]      in_tdata,
  // in_tuser: command [1:0]
  input  logic [wfit_pkg::IN_TUSER_W-1:0]      in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // out_tdata: slot_valid [0], slot_key [64:1], slot_count [104:65], occupancy [111:105]
  output logic [wfit_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // out_tuser: outcome [2:0]
  output logic [wfit_pkg::OUT_TUSER_W-1:0]     out_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wfit_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wfit_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int KW = wfit_pkg::KEY_W;
  localparam int WW = wfit_pkg::WEIGHT_W;
  localparam int SW = wfit_pkg::SLOT_W;

  logic [wfit_pkg::CAP_W-1:0]       cap_r;
  logic                             wide_r;
  wfit_pkg::cfg_t                   cfg;
  wfit_pkg::req_t                   req;
  wfit_pkg::res_t                   res;
  logic                             res_valid, res_take;
  logic                             out_tvalid_r;
  logic [wfit_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic [wfit_pkg::OUT_TUSER_W-1:0] out_tuser_r;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= wfit_pkg::CAP_RESET;
      wide_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        wfit_pkg::REG_CAPACITY:  cap_r  <= cfg_data;
        wfit_pkg::REG_WIDE_KEYS: wide_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.capacity = cap_r;
  assign cfg.wide     = wide_r;

  // unpack the input word
  assign req.cmd    = in_tuser[wfit_pkg::CMD_W-1:0];
  assign req.key    = in_tdata[KW-1:0];
  assign req.weight = in_tdata[KW+WW-1:KW];
  assign req.slot   = in_tdata[KW+WW+SW-1:KW+WW];

  wfit_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .req_valid(in_tvalid),
    .req      (req),
    .req_ready(in_tready),
    .res_valid(res_valid),
    .res_take (res_take),
    .res      (res)
  );

  // output register: loads when empty or being drained
  assign res_take = res_valid && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_take) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_tdata_r <= wfit_pkg::OUT_TDATA_W'({res.occupancy, res.slot_count,
                                             res.slot_key, res.slot_valid});
      out_tuser_r <= res.outcome;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
